// ===== rtl/lpnt_pkg.sv =====
// lpnt_pkg: shared sizes and result codes for the linear probe name table
// used by linear_probe_name_table; depends on nothing else

package lpnt_pkg;

    // table size is a power of two so the hash and probe wrap are plain masks
    localparam int SLOT_W      = 6;
    localparam int TABLE_SLOTS = 1 << SLOT_W;

    // name field is fixed at eight bytes; NAME_BYTES limits how many count
    localparam int NAME_W      = 64;
    localparam int NAME_CHARS  = NAME_W / 8;
    localparam int BYTE_IDX_W  = $clog2(NAME_CHARS);
    localparam int NAME_BYTES  = 8;
    localparam int HANDLE_W    = 16;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

endpackage

// ===== rtl/linear_probe_name_table.sv =====
// linear_probe_name_table: open addressing name table with linear probing
// depends on lpnt_pkg for sizes, command and status codes
//
// usage: an item on the input channel (i_valid / o_stall) is an add or a
// search of a name of up to eight bytes, first byte lowest, ending at the
// first zero byte. an add stores the handle in the first free slot from the
// hash onward; a zero handle is ignored and a full circle reports full.
// a search returns the first matching slot's handle, or not found at a free
// slot or after a full circle. one result per item on the output channel
// (o_valid / i_stall), held stable while stalled.
// flow: o_stall is low only while the block is idle. an item passes
// through an accept step, a hash step per name byte through the shared 9x8
// hash multiplier plus one to see the terminator when the name is shorter
// than eight bytes, a probe step per slot on an add or a probe and a check
// per occupied slot on a search (slot store read is registered), and a
// step to load the output register; a zero handle add skips hash and probe.
// the next item is taken while a result still waits; it finishes its work
// and then holds until the output register is free. reset (synchronous,
// active low) clears all occupancy bits at once and empties the output
// register; the name and handle stores are not cleared.

module linear_probe_name_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [lpnt_pkg::NAME_W-1:0]   i_name_bytes,
    input  logic [lpnt_pkg::HANDLE_W-1:0] i_client_handle,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [lpnt_pkg::HANDLE_W-1:0] o_found_handle
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_PROBE = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam logic [lpnt_pkg::BYTE_IDX_W-1:0] LAST_BYTE =
        lpnt_pkg::BYTE_IDX_W'(lpnt_pkg::NAME_BYTES - 1);

    t_state                              r_state, n_state;
    logic                                r_cmd, n_cmd;
    logic [lpnt_pkg::NAME_W-1:0]         r_name, n_name;
    logic [lpnt_pkg::HANDLE_W-1:0]       r_handle, n_handle;
    logic [lpnt_pkg::BYTE_IDX_W-1:0]     r_byte, n_byte;
    logic [lpnt_pkg::SLOT_W-1:0]         r_idx, n_idx;
    logic [lpnt_pkg::SLOT_W-1:0]         r_start, n_start;
    lpnt_pkg::t_status                   r_res_status, n_res_status;
    logic [lpnt_pkg::HANDLE_W-1:0]       r_res_handle, n_res_handle;
    logic [lpnt_pkg::TABLE_SLOTS-1:0]    r_used;
    logic                                r_out_valid, n_out_valid;
    logic [1:0]                          r_out_status, n_out_status;
    logic [lpnt_pkg::HANDLE_W-1:0]       r_out_handle, n_out_handle;

    logic [lpnt_pkg::NAME_W-1:0]         m_name   [lpnt_pkg::TABLE_SLOTS];
    logic [lpnt_pkg::HANDLE_W-1:0]       m_handle [lpnt_pkg::TABLE_SLOTS];
    logic [lpnt_pkg::NAME_W-1:0]         r_rd_name;
    logic [lpnt_pkg::HANDLE_W-1:0]       r_rd_handle;

    logic                                accept;
    logic                                mem_we;
    logic [lpnt_pkg::NAME_W-1:0]         clean_name;
    logic [lpnt_pkg::NAME_CHARS-1:0][7:0] name_arr;
    logic [7:0]                          cur_byte;
    logic [8:0]                          hash_sum;
    logic [16:0]                         hash_prod;
    logic [lpnt_pkg::SLOT_W-1:0]         hash_next;
    logic [lpnt_pkg::SLOT_W-1:0]         idx_inc;
    logic                                out_free;

    assign o_stall        = (r_state != S_IDLE);
    assign accept         = i_valid && (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_handle = r_out_handle;
    assign out_free       = !r_out_valid || !i_stall;

    // drop bytes after the first zero and beyond the name length
    always_comb begin
        logic alive;
        alive      = 1'b1;
        clean_name = '0;
        for (int i = 0; i < lpnt_pkg::NAME_CHARS; i++) begin
            alive = alive && (i_name_bytes[8*i +: 8] != 8'd0)
                    && (i < lpnt_pkg::NAME_BYTES);
            if (alive) begin
                clean_name[8*i +: 8] = i_name_bytes[8*i +: 8];
            end
        end
    end

    // shared hash step: ((h + c) * c) mod table size
    assign name_arr  = r_name;
    assign cur_byte  = name_arr[r_byte];
    assign hash_sum  = {3'd0, r_idx} + {1'b0, cur_byte};
    assign hash_prod = {8'd0, hash_sum} * {9'd0, cur_byte};
    assign hash_next = hash_prod[lpnt_pkg::SLOT_W-1:0];
    assign idx_inc   = r_idx + lpnt_pkg::SLOT_W'(1);

    assign mem_we = (r_state == S_PROBE) && (r_cmd == lpnt_pkg::CMD_ADD)
                    && !r_used[r_idx];

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_name       = r_name;
        n_handle     = r_handle;
        n_byte       = r_byte;
        n_idx        = r_idx;
        n_start      = r_start;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd        = i_command;
                    n_name       = clean_name;
                    n_handle     = i_client_handle;
                    n_byte       = '0;
                    n_idx        = '0;
                    n_res_status = lpnt_pkg::ST_STORED;
                    n_res_handle = '0;
                    if (i_command == lpnt_pkg::CMD_ADD && i_client_handle == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (cur_byte == 8'd0) begin
                    n_start = r_idx;
                    n_state = S_PROBE;
                end else begin
                    n_idx  = hash_next;
                    n_byte = r_byte + lpnt_pkg::BYTE_IDX_W'(1);
                    if (r_byte == LAST_BYTE) begin
                        n_start = hash_next;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_cmd == lpnt_pkg::CMD_ADD) begin
                    if (!r_used[r_idx]) begin
                        n_res_status = lpnt_pkg::ST_STORED;
                        n_state      = S_DONE;
                    end else if (idx_inc == r_start) begin
                        n_res_status = lpnt_pkg::ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_idx = idx_inc;
                    end
                end else begin
                    if (!r_used[r_idx]) begin
                        n_res_status = lpnt_pkg::ST_MISSING;
                        n_state      = S_DONE;
                    end else begin
                        // slot store read lands next cycle
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_rd_name == r_name) begin
                    n_res_status = lpnt_pkg::ST_FOUND;
                    n_res_handle = r_rd_handle;
                    n_state      = S_DONE;
                end else if (idx_inc == r_start) begin
                    n_res_status = lpnt_pkg::ST_MISSING;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (mem_we) begin
                r_used[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_name       <= n_name;
        r_handle     <= n_handle;
        r_byte       <= n_byte;
        r_idx        <= n_idx;
        r_start      <= n_start;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_name[r_idx]   <= r_name;
            m_handle[r_idx] <= r_handle;
        end
        r_rd_name   <= m_name[r_idx];
        r_rd_handle <= m_handle[r_idx];
    end

endmodule
